### sv/ekn_pkg.sv
// Package with the beat types, table structs and constants of the k-nearest buffer.
package ekn_pkg;

  localparam int K_MAX_DEF = 16;
  localparam int IDX_MAX_W = 8;
  localparam int DIST_W = 24;
  localparam int ID_W = 32;
  localparam int SUM_W = 48;
  localparam int NC_W = 5;
  localparam logic [NC_W-1:0] NC_RESET = 5'd16;

  typedef struct packed {
    logic signed [15:0] candidate_element;
    logic signed [15:0] query_element;
    logic [ID_W-1:0]    candidate_id;
    logic               last_element;
  } in_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              kept;
    logic [3:0]        slot;
    logic [ID_W-1:0]   kept_id;
  } out_beat_t;

  typedef struct packed {
    logic                 valid;
    logic [DIST_W-1:0]    max_dist;
    logic [IDX_MAX_W-1:0] max_idx;
  } wave_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    logic [DIST_W-1:0]    dist_val;
    logic [ID_W-1:0]      id;
  } cell_wr_t;

endpackage

### sv/ekn_sqrt.sv
// Iterative floor square root of a 48-bit value, two radicand bits per cycle.
module ekn_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ekn_pkg::SUM_W-1:0] operand,
  output logic                      busy,
  output logic                      done,
  output logic [ekn_pkg::DIST_W-1:0] root
);
  import ekn_pkg::*;

  logic [SUM_W-1:0]  rad_r;
  logic [25:0]       rem_r;
  logic [DIST_W-1:0] root_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [27:0]       rem_sh;
  logic [27:0]       trial;
  logic              ge;

  assign rem_sh = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(DIST_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
      rem_r  <= ge ? 26'(rem_sh - trial) : 26'(rem_sh);
      root_r <= {root_r[DIST_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

### sv/ekn_cell.sv
// One table cell: holds an entry and passes the worst-entry search wave on to its neighbour.
module ekn_cell #(
  parameter int K_MAX = ekn_pkg::K_MAX_DEF,
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(K_MAX+1)-1:0]       k_eff,
  input  ekn_pkg::cell_wr_t                wr,
  input  ekn_pkg::wave_t                   wave_in,
  output ekn_pkg::wave_t                   wave_out
);
  import ekn_pkg::*;

  localparam int CNT_W = $clog2(K_MAX + 1);

  logic [DIST_W-1:0] dist_r;
  logic [ID_W-1:0]   id_r;
  wave_t             wave_r;
  wave_t             wave_nxt;
  logic              take;

  assign take = (CNT_W'(INDEX) < k_eff) && (dist_r > wave_in.max_dist);

  always_comb begin
    wave_nxt = wave_in;
    if (take) begin
      wave_nxt.max_dist = dist_r;
      wave_nxt.max_idx  = IDX_MAX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.valid <= 1'b0;
    end else begin
      wave_r.valid <= wave_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    wave_r.max_dist <= wave_nxt.max_dist;
    wave_r.max_idx  <= wave_nxt.max_idx;
    if (wr.en && (wr.idx == IDX_MAX_W'(INDEX))) begin
      dist_r <= wr.dist_val;
      id_r   <= wr.id;
    end
  end

  assign wave_out = wave_r;

endmodule

### sv/euclidean_k_nearest_buffer.sv
// Top level of the Euclidean k-nearest-neighbour buffer.
// Usage: drive one element pair per beat on in_data and raise start; a beat is
// taken at an edge where start is high and busy is low. Elements that are not
// last are taken back to back, one per cycle, and only add to the running sum.
// The beat marked last_element makes busy rise; the block then takes the
// square root, one result bit per cycle, and offers the candidate to the
// table of cells. While the table is not full the result follows the root
// at once; otherwise a search wave runs down the row of K_MAX cells, one
// cell per cycle, before the result appears.
// Each result is shown on out_data for one cycle with out_valid high; the
// receiver cannot stall the block. cfg_we writes neighbor_count from cfg_wdata
// and should only be used while the block is idle.
// After reset the sum and fill count are zero, neighbor_count is 16 and the
// table entries are undefined until filled.
module euclidean_k_nearest_buffer #(
  parameter int K_MAX = ekn_pkg::K_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  ekn_pkg::in_beat_t        in_data,
  output logic                     out_valid,
  output ekn_pkg::out_beat_t       out_data,
  input  logic                     cfg_we,
  input  logic [ekn_pkg::NC_W-1:0] cfg_wdata
);
  import ekn_pkg::*;

  localparam int CNT_W = $clog2(K_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROOT = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t            st_r;
  state_t            st_nxt;
  logic [NC_W-1:0]   nc_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  k_eff;
  logic [31:0]       sq_r;
  logic              sq_vld_r;
  logic              last_r;
  logic [ID_W-1:0]   id_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [DIST_W-1:0] dist_r;
  logic              accept;
  logic              root_start;
  logic              root_busy;
  logic              root_done;
  logic [DIST_W-1:0] root;
  logic signed [16:0] diff;
  logic [15:0]       mag;
  wave_t             head;
  wave_t             waves [K_MAX];
  wave_t             tail;
  cell_wr_t          wr;
  logic              out_valid_r;
  out_beat_t         out_r;
  out_beat_t         out_nxt;
  logic              emit;

  assign accept = start && !busy;
  assign busy   = (st_r != ST_IDLE) || (sq_vld_r && last_r);

  assign diff = 17'(in_data.candidate_element) - 17'(in_data.query_element);
  assign mag  = diff[16] ? 16'(-diff) : 16'(diff);

  always_comb begin
    if (nc_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(nc_r) > 32'(K_MAX)) begin
      k_eff = CNT_W'(K_MAX);
    end else begin
      k_eff = CNT_W'(nc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_RESET;
    end else if (cfg_we) begin
      nc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      sq_vld_r <= accept;
      last_r   <= accept && in_data.last_element;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r <= mag * mag;
      id_r <= in_data.candidate_id;
    end
  end

  assign sum_ext = {1'b0, sum_r} + {17'b0, sq_r};
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign root_start = sq_vld_r && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (sq_vld_r) begin
      sum_r <= last_r ? '0 : sum_sat;
    end
  end

  ekn_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .operand (sum_sat),
    .busy    (root_busy),
    .done    (root_done),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    if (root_done) begin
      dist_r <= root;
    end
  end

  always_comb begin
    head          = '0;
    head.valid    = (st_r == ST_ROOT) && root_done && (fill_r >= k_eff);
    st_nxt        = st_r;
    fill_nxt      = fill_r;
    wr            = '0;
    emit          = 1'b0;
    out_nxt       = '0;
    out_nxt.kept_id = id_r;
    case (st_r)
      ST_IDLE: begin
        if (root_start) begin
          st_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          if (fill_r < k_eff) begin
            wr.en       = 1'b1;
            wr.idx      = IDX_MAX_W'(fill_r);
            wr.dist_val = root;
            wr.id       = id_r;
            fill_nxt = fill_r + CNT_W'(1);
            emit     = 1'b1;
            out_nxt.distance = root;
            out_nxt.kept     = 1'b1;
            out_nxt.slot     = 4'(fill_r);
            st_nxt   = ST_IDLE;
          end else begin
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          emit = 1'b1;
          out_nxt.distance = dist_r;
          if (dist_r < tail.max_dist) begin
            wr.en       = 1'b1;
            wr.idx      = tail.max_idx;
            wr.dist_val = dist_r;
            wr.id       = id_r;
            out_nxt.kept = 1'b1;
            out_nxt.slot = 4'(tail.max_idx);
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    ekn_cell #(
      .K_MAX (K_MAX),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .k_eff    (k_eff),
      .wr       (wr),
      .wave_in  ((i == 0) ? head : waves[(i == 0) ? 0 : i - 1]),
      .wave_out (waves[i])
    );
  end

  assign tail      = waves[K_MAX-1];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(K_MAX))
    else $error("fill count beyond table size");

  a_root_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    root_start |-> !root_busy && (st_r == ST_IDLE))
    else $error("square root started while still working");

  a_scan_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> busy && !root_busy)
    else $error("table scan overlaps other work");

endmodule
